// ===== design/cimc_pkg.sv =====
// cimc_pkg: shared constants, types and functions of the cross-shaped
// character-image morphology block
// no dependencies
package cimc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int IMG_W_W     = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_CFG_W = 11;
    localparam int CMP_W       = (IMG_W_W > WIDTH_CFG_W) ? IMG_W_W : WIDTH_CFG_W;
    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CHAR_W-1:0] BG_CHAR = 8'h2E;

    localparam logic [1:0]             MODE_RST   = 2'd0;
    localparam logic [CHAR_W-1:0]      TARGET_RST = 8'd35;
    localparam logic [CHAR_W-1:0]      OTHER_RST  = 8'd46;
    localparam logic [WIDTH_CFG_W-1:0] IMG_W_RST  = 11'd64;

    typedef enum logic [1:0] {
        MODE_REPLACE = 2'd0,
        MODE_ERODE   = 2'd1,
        MODE_DILATE  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_TARGET = 2'd1,
        CFG_OTHER  = 2'd2,
        CFG_IMG_W  = 2'd3
    } t_cfg_idx;

    // one line buffer entry: valid flag and character
    typedef struct packed {
        logic              vld;
        logic [CHAR_W-1:0] ch;
    } t_cell;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] col;
    } t_lb_rd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] col;
        t_cell             up;
        t_cell             mid;
    } t_lb_wr;

    // configured width clamped to 1..MAX_WIDTH
    function automatic logic [IMG_W_W-1:0] eff_width(input logic [WIDTH_CFG_W-1:0] w);
        logic [CMP_W-1:0] wx;
        wx = CMP_W'(w);
        if (wx == '0) begin
            wx = CMP_W'(1);
        end else if (wx > CMP_W'(MAX_WIDTH)) begin
            wx = CMP_W'(MAX_WIDTH);
        end
        return IMG_W_W'(wx);
    endfunction

    function automatic logic is_char(input t_cell e, input logic [CHAR_W-1:0] ch);
        return e.vld && (e.ch == ch);
    endfunction

    // processed character for a valid centre
    function automatic logic [CHAR_W-1:0] cross_op(
        input logic [1:0]        mode,
        input logic [CHAR_W-1:0] tgt,
        input logic [CHAR_W-1:0] oth,
        input t_cell             left,
        input t_cell             centre,
        input t_cell             right,
        input t_cell             up,
        input t_cell             down
    );
        logic [CHAR_W-1:0] res;
        logic              hit_oth;
        logic              hit_tgt;
        res     = centre.ch;
        hit_oth = is_char(up, oth) || is_char(down, oth) ||
                  is_char(left, oth) || is_char(right, oth);
        hit_tgt = is_char(up, tgt) || is_char(down, tgt) ||
                  is_char(left, tgt) || is_char(right, tgt);
        case (mode)
            MODE_REPLACE: begin
                if (centre.ch == tgt) res = oth;
            end
            MODE_ERODE: begin
                if (centre.ch == tgt && hit_oth) res = oth;
            end
            MODE_DILATE: begin
                if (centre.ch == BG_CHAR && hit_tgt) res = tgt;
            end
            default: begin
                res = centre.ch;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== design/cimc_in_if.sv =====
// cimc_in_if: input pixel channel, valid/ready with op, frame_start, pixel
// depends on cimc_pkg
interface cimc_in_if import cimc_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              op;
    logic              frame_start;
    logic [CHAR_W-1:0] pixel;

    modport source (output valid, output op, output frame_start, output pixel, input ready);
    modport sink   (input valid, input op, input frame_start, input pixel, output ready);
endinterface

// ===== design/cimc_out_if.sv =====
// cimc_out_if: result channel, valid/ready with out_pixel and row_end
// depends on cimc_pkg
interface cimc_out_if import cimc_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_pixel;
    logic              row_end;

    modport source (output valid, output out_pixel, output row_end, input ready);
    modport sink   (input valid, input out_pixel, input row_end, output ready);
endinterface

// ===== design/cimc_line_buf.sv =====
// cimc_line_buf: upper and middle line memories, one write and one
// registered read each per cycle, with write-first bypass
// depends on cimc_pkg
module cimc_line_buf import cimc_pkg::*; (
    input  logic   i_clk,
    input  t_lb_rd i_rd,
    input  t_lb_wr i_wr,
    output t_cell  o_up,
    output t_cell  o_mid
);

    t_cell             r_up_mem  [MAX_WIDTH];
    t_cell             r_mid_mem [MAX_WIDTH];
    t_cell             r_up_q;
    t_cell             r_mid_q;
    logic [ADDR_W-1:0] mid_addr;

    // middle line is read one column ahead (right neighbour)
    assign mid_addr = i_rd.col + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_up_mem[i_wr.col]  <= i_wr.up;
            r_mid_mem[i_wr.col] <= i_wr.mid;
        end
        if (i_rd.re) begin
            if (i_wr.we && i_wr.col == i_rd.col) begin
                r_up_q <= i_wr.up;
            end else begin
                r_up_q <= r_up_mem[i_rd.col];
            end
            if (i_wr.we && i_wr.col == mid_addr) begin
                r_mid_q <= i_wr.mid;
            end else begin
                r_mid_q <= r_mid_mem[mid_addr];
            end
        end
    end

    assign o_up  = r_up_q;
    assign o_mid = r_mid_q;

endmodule

// ===== design/char_image_morphology_cross_top.sv =====
// char_image_morphology_cross_top: cross-shaped 3x3 morphology on a character
// raster stream; depends on cimc_pkg, cimc_in_if, cimc_out_if, cimc_line_buf
//
// One pixel transaction is taken every clock cycle while the output is not
// stalled. The result for an image position leaves when the transaction one
// row below it (pixel or flush) is taken, through the window stage and the
// output register; pixels of the first row of a frame give no result, and
// one row of flush transactions pushes out the last row. The rate is set by
// the two line memories, each doing one read and one write per cycle. Validity
// of the line memories is tracked with a row-complete flag, so there is no
// clearing pass after reset or frame start. Width is latched at frame start.
module char_image_morphology_cross_top import cimc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cimc_in_if.sink               i_in,
    cimc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [1:0]             r_mode;
    logic [CHAR_W-1:0]      r_target;
    logic [CHAR_W-1:0]      r_other;
    logic [WIDTH_CFG_W-1:0] r_img_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_target <= TARGET_RST;
            r_other  <= OTHER_RST;
            r_img_w  <= IMG_W_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_TARGET: r_target <= i_cfg_data[CHAR_W-1:0];
                CFG_OTHER:  r_other  <= i_cfg_data[CHAR_W-1:0];
                CFG_IMG_W:  r_img_w  <= i_cfg_data[WIDTH_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input side: column tracking and memory read issue
    logic [IMG_W_W-1:0] r_fill;
    logic [ADDR_W-1:0]  r_col;
    logic               r_hist;
    logic               r_s1_vld;
    logic               r_out_vld;

    logic [IMG_W_W-1:0] w_cur;
    logic [ADDR_W-1:0]  c_cur;
    logic               hist_cur;
    logic               last_cur;
    logic               s1_adv;
    logic               in_rdy;
    logic               accept;

    assign s1_adv = !r_out_vld || o_out.ready;
    assign in_rdy = !r_s1_vld || s1_adv;
    assign accept = i_in.valid && in_rdy;
    assign i_in.ready = in_rdy;

    always_comb begin
        if (i_in.frame_start || r_fill == '0) begin
            w_cur = eff_width(r_img_w);
        end else begin
            w_cur = r_fill;
        end
        c_cur    = i_in.frame_start ? '0 : r_col;
        hist_cur = !i_in.frame_start && r_hist;
        last_cur = (IMG_W_W'(c_cur) + IMG_W_W'(1)) == w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_col  <= '0;
            r_hist <= 1'b0;
        end else if (accept) begin
            r_fill <= w_cur;
            r_col  <= last_cur ? '0 : c_cur + ADDR_W'(1);
            // a full row seen in this frame: line memories now hold it
            r_hist <= hist_cur || last_cur;
        end
    end

    // window stage registers
    logic              r_s1_op;
    logic [CHAR_W-1:0] r_s1_px;
    logic [ADDR_W-1:0] r_s1_col;
    logic              r_s1_last;
    logic              r_s1_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_rdy) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_in.op;
            r_s1_px   <= i_in.pixel;
            r_s1_col  <= c_cur;
            r_s1_last <= last_cur;
            r_s1_hist <= hist_cur;
        end
    end

    // line memories
    t_lb_rd lb_rd;
    t_lb_wr lb_wr;
    t_cell  rd_up;
    t_cell  rd_mid;

    cimc_line_buf u_line_buf (
        .i_clk (i_clk),
        .i_rd  (lb_rd),
        .i_wr  (lb_wr),
        .o_up  (rd_up),
        .o_mid (rd_mid)
    );

    // window and result
    t_cell             r_mid0;
    t_cell             r_win_c;
    t_cell             r_win_r;
    t_cell             left;
    t_cell             centre;
    t_cell             right;
    t_cell             up;
    t_cell             down;
    logic [CHAR_W-1:0] res_px;

    always_comb begin
        up    = r_s1_hist ? rd_up : '0;
        right = (r_s1_hist && !r_s1_last) ? rd_mid : '0;
        if (r_s1_col == '0) begin
            left   = '0;
            centre = r_s1_hist ? r_mid0 : '0;
        end else begin
            left   = r_win_c;
            centre = r_win_r;
        end
        down.vld = !r_s1_op;
        down.ch  = r_s1_op ? '0 : r_s1_px;
        res_px   = cross_op(r_mode, r_target, r_other, left, centre, right, up, down);
    end

    always_comb begin
        lb_rd.re  = accept;
        lb_rd.col = c_cur;
        lb_wr.we  = r_s1_vld && s1_adv;
        lb_wr.col = r_s1_col;
        lb_wr.up  = centre;
        lb_wr.mid = down;
    end

    always_ff @(posedge i_clk) begin
        if (lb_wr.we) begin
            r_win_c <= centre;
            r_win_r <= right;
            if (r_s1_col == '0) begin
                r_mid0 <= down;
            end
        end
    end

    // output register
    logic [CHAR_W-1:0] r_out_px;
    logic              r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld && centre.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_px  <= res_px;
            r_out_end <= r_s1_last;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_pixel = r_out_px;
    assign o_out.row_end   = r_out_end;

`ifndef ASSERT_OFF
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != '0 |-> IMG_W_W'(r_col) < r_fill)
        else $error("column counter outside latched width");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= IMG_W_W'(MAX_WIDTH))
        else $error("latched width above line buffer depth");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("input stalled with empty output register");

    a_no_result_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && s1_adv && !r_s1_hist |=> !r_out_vld)
        else $error("result produced before a full row was seen");
`endif

endmodule
